/* sv/rarm_pkg.sv */
// shared constants, types and helpers for the rational add/multiply/reduce block
package rarm_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;

    typedef logic [VALUE_WIDTH-1:0] t_mag;
    typedef logic [PROD_WIDTH-1:0]  t_prod;
    typedef logic [FIELD_WIDTH-1:0] t_field;

    // sign-magnitude operand
    typedef struct packed {
        logic neg;
        t_mag mag;
    } t_opnd;

    // magnitude of the most negative value at the result width
    localparam t_prod SIGN_MAG = t_prod'(1) << (VALUE_WIDTH - 1);

    // operation kinds
    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_MUL = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;

    // split the low bits of a field into sign and magnitude
    function automatic t_opnd to_opnd(input t_field f);
        t_opnd r;
        t_mag  v;
        v     = f[VALUE_WIDTH-1:0];
        r.neg = v[VALUE_WIDTH-1];
        r.mag = r.neg ? (~v + t_mag'(1)) : v;
        return r;
    endfunction

endpackage

/* sv/rarm_in_if.sv */
// input channel: operation kind and two fractions
interface rarm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] left_num;
    logic [31:0] left_den;
    logic [31:0] right_num;
    logic [31:0] right_den;

    modport source (output valid, kind, left_num, left_den, right_num, right_den,
                    input ready);
    modport sink   (input valid, kind, left_num, left_den, right_num, right_den,
                    output ready);
endinterface

/* sv/rarm_out_if.sv */
// output channel: reduced fraction and status
interface rarm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_num;
    logic [31:0] result_den;
    logic [1:0]  status;

    modport source (output valid, result_num, result_den, status, input ready);
    modport sink   (input valid, result_num, result_den, status, output ready);
endinterface

/* sv/rarm_mul.sv */
// shift-add multiplier, one multiplier bit per cycle
module rarm_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rarm_pkg::t_mag i_a,
    input  rarm_pkg::t_mag i_b,
    output rarm_pkg::t_prod o_prod,
    output logic           o_done
);
    import rarm_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    t_prod         r_acc, r_mcand;
    t_mag          r_mplier;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= t_prod'(i_a);
            r_mplier <= i_b;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;
endmodule

/* sv/rarm_gcd.sv */
// binary gcd, one halving or subtraction per cycle
module rarm_gcd (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rarm_pkg::t_prod i_a,
    input  rarm_pkg::t_prod i_b,
    output rarm_pkg::t_prod o_gcd,
    output logic            o_done
);
    import rarm_pkg::*;

    localparam int KW = $clog2(PROD_WIDTH + 1);
    localparam logic [1:0] G_IDLE = 2'd0;
    localparam logic [1:0] G_RUN  = 2'd1;
    localparam logic [1:0] G_SHL  = 2'd2;

    logic [1:0]    r_state;
    logic          r_done;
    logic [KW-1:0] r_k;
    t_prod         r_a, r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_k     <= '0;
                        r_state <= G_RUN;
                    end
                end
                G_RUN: begin
                    // reduce until one side is zero
                    if (r_a == '0) begin
                        r_a     <= r_b;
                        r_state <= G_SHL;
                    end else if (r_b == '0) begin
                        r_state <= G_SHL;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a >= r_b) begin
                        r_a <= r_a - r_b;
                    end else begin
                        r_b <= r_b - r_a;
                    end
                end
                G_SHL: begin
                    // restore the common power of two
                    if (r_k == '0) begin
                        r_done  <= 1'b1;
                        r_state <= G_IDLE;
                    end else begin
                        r_a <= r_a << 1;
                        r_k <= r_k - KW'(1);
                    end
                end
                default: r_state <= G_IDLE;
            endcase
        end
    end

    assign o_gcd  = r_a;
    assign o_done = r_done;
endmodule

/* sv/rarm_div.sv */
// restoring divider, one quotient bit per cycle
module rarm_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rarm_pkg::t_prod i_num,
    input  rarm_pkg::t_prod i_den,
    output rarm_pkg::t_prod o_quo,
    output logic            o_done
);
    import rarm_pkg::*;

    localparam int CW = $clog2(PROD_WIDTH + 1);

    logic              r_busy, r_done;
    logic [CW-1:0]     r_cnt;
    t_prod             r_rem, r_quo, r_den;
    logic [PROD_WIDTH:0] rem_sh, rem_sub;
    logic              q_bit;

    // trial subtraction
    always_comb begin
        rem_sh  = {r_rem, r_quo[PROD_WIDTH-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = (rem_sh >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(PROD_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[PROD_WIDTH-1:0] : rem_sh[PROD_WIDTH-1:0];
            r_quo <= {r_quo[PROD_WIDTH-2:0], q_bit};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule

/* sv/rational_add_multiply_reduce_top.sv */
// rational add/multiply with gcd reduction, one item at a time
// steps: 2 (multiply) or 3 (add) shift-add multiplies, a binary gcd, then 2 divides; a zero den
//   skips the gcd and the divides
// flow: input ready only while the sequencer idles; a finished result waits in the output
//   register while the next item is taken
// reset: synchronous active-low, clears the sequencer and the output valid
module rational_add_multiply_reduce_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rarm_in_if.sink     i_in_ch,
    rarm_out_if.source  o_out_ch
);
    import rarm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_DIV1 = 4'd6;
    localparam logic [3:0] S_DIV2 = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state;
    logic       r_mul_start, r_gcd_start, r_div_start;
    logic       r_kind, r_zden;
    t_opnd      r_ln, r_ld, r_rn, r_rd;
    t_prod      r_p1, r_p2, r_g;
    logic       r_s1, r_s2;
    logic       r_num_neg, r_den_neg;
    t_prod      r_num_mag, r_den_mag;
    logic       r_out_valid;
    t_field     r_out_num, r_out_den;
    logic [1:0] r_out_status;

    t_mag  mul_a, mul_b;
    t_prod mul_prod, gcd_val, div_num, div_quo;
    logic  mul_done, gcd_done, div_done;
    logic  in_xfer, out_free;
    logic  a_neg, b_neg, sum_neg;
    t_prod sum_mag;
    t_prod num_bits, den_bits;
    logic  num_fits, den_fits;

    assign in_xfer  = i_in_ch.valid && i_in_ch.ready;
    assign out_free = !r_out_valid || o_out_ch.ready;

    // multiplier operand select
    always_comb begin
        case (r_state)
            S_MUL1: begin
                mul_a = r_ln.mag;
                mul_b = (r_kind == KIND_MUL) ? r_rn.mag : r_rd.mag;
            end
            S_MUL2: begin
                mul_a = r_rn.mag;
                mul_b = r_ld.mag;
            end
            default: begin
                mul_a = r_ld.mag;
                mul_b = r_rd.mag;
            end
        endcase
    end

    assign div_num = (r_state == S_DIV1) ? r_num_mag : r_den_mag;

    // signed magnitude sum of the cross products
    always_comb begin
        a_neg = r_s1 && (r_p1 != '0);
        b_neg = r_s2 && (r_p2 != '0);
        if (a_neg == b_neg) begin
            sum_mag = r_p1 + r_p2;
            sum_neg = a_neg;
        end else if (r_p1 >= r_p2) begin
            sum_mag = r_p1 - r_p2;
            sum_neg = a_neg;
        end else begin
            sum_mag = r_p2 - r_p1;
            sum_neg = b_neg;
        end
        if (sum_mag == '0) begin
            sum_neg = 1'b0;
        end
    end

    // result formatting and range check
    always_comb begin
        num_bits = r_num_neg ? (t_prod'(0) - r_num_mag) : r_num_mag;
        den_bits = r_den_neg ? (t_prod'(0) - r_den_mag) : r_den_mag;
        num_fits = r_num_neg ? (r_num_mag <= SIGN_MAG) : (r_num_mag < SIGN_MAG);
        den_fits = r_den_neg ? (r_den_mag <= SIGN_MAG) : (r_den_mag < SIGN_MAG);
    end

    rarm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    rarm_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_gcd_start),
        .i_a     (r_num_mag),
        .i_b     (r_den_mag),
        .o_gcd   (gcd_val),
        .o_done  (gcd_done)
    );

    rarm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (div_num),
        .i_den   (r_g),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_gcd_start <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_gcd_start <= 1'b0;
            r_div_start <= 1'b0;
            // output valid: set on a new result, cleared on transfer
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_kind      <= i_in_ch.kind;
                        r_ln        <= to_opnd(i_in_ch.left_num);
                        r_ld        <= to_opnd(i_in_ch.left_den);
                        r_rn        <= to_opnd(i_in_ch.right_num);
                        r_rd        <= to_opnd(i_in_ch.right_den);
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    if (mul_done) begin
                        r_p1        <= mul_prod;
                        r_s1        <= r_ln.neg ^ ((r_kind == KIND_MUL) ? r_rn.neg : r_rd.neg);
                        r_p2        <= '0;
                        r_s2        <= 1'b0;
                        r_mul_start <= 1'b1;
                        r_state     <= (r_kind == KIND_MUL) ? S_MUL3 : S_MUL2;
                    end
                end
                S_MUL2: begin
                    if (mul_done) begin
                        r_p2        <= mul_prod;
                        r_s2        <= r_rn.neg ^ r_ld.neg;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL3;
                    end
                end
                S_MUL3: begin
                    if (mul_done) begin
                        r_den_mag <= mul_prod;
                        r_den_neg <= (r_ld.neg ^ r_rd.neg) && (mul_prod != '0);
                        r_state   <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_den_mag == '0) begin
                        r_zden    <= 1'b1;
                        r_num_mag <= '0;
                        r_num_neg <= 1'b0;
                        r_den_neg <= 1'b0;
                        r_state   <= S_OUT;
                    end else begin
                        r_zden      <= 1'b0;
                        r_num_mag   <= sum_mag;
                        r_num_neg   <= sum_neg;
                        r_gcd_start <= 1'b1;
                        r_state     <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (gcd_done) begin
                        r_g         <= gcd_val;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_num_mag   <= div_quo;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_den_mag <= div_quo;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hand the result to the output register once it is free
                    if (out_free) begin
                        r_out_num   <= t_field'($signed(num_bits[VALUE_WIDTH-1:0]));
                        r_out_den   <= t_field'($signed(den_bits[VALUE_WIDTH-1:0]));
                        if (r_zden) begin
                            r_out_status <= ST_ZDEN;
                        end else if (num_fits && den_fits) begin
                            r_out_status <= ST_OK;
                        end else begin
                            r_out_status <= ST_OVF;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in_ch.ready       = (r_state == S_IDLE);
    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.result_num = r_out_num;
    assign o_out_ch.result_den = r_out_den;
    assign o_out_ch.status     = r_out_status;
endmodule
